### sv/packet_timestamp_monotonizer_assert.svh
// Assertion macros used by the checker.
`ifndef PACKET_TIMESTAMP_MONOTONIZER_ASSERT_SVH
`define PACKET_TIMESTAMP_MONOTONIZER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PTM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PTM_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/ptm_pkg.sv
package ptm_pkg;

  localparam int TS_W            = 64;
  localparam int STREAM_W        = 8;
  localparam int KIND_W          = 2;
  localparam int STATUS_W        = 3;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Item kinds; the unused fourth code passes through like a marker.
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MONOTONIC_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_STREAM    = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_WRONG_STREAM = 3'd1,
    ST_NO_TS        = 3'd2,
    ST_PTS_OVF      = 3'd3,
    ST_DTS_OVF      = 3'd4,
    ST_ADV_OVF      = 3'd5
  } status_t;

  // One classified request, as handed from the front to the back.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    status_t           status;       // status decided up front
    logic              act;          // run the monotonic update
    logic [TS_W-1:0]   pts;
    logic              pts_valid;
    logic [TS_W-1:0]   dts;
    logic              dts_valid;
    logic [TS_W-1:0]   dur;
    logic [TS_W-1:0]   min_ts;       // smallest present timestamp
    logic [TS_W-1:0]   pts_off;      // pts - min_ts, unsigned
    logic [TS_W-1:0]   dts_off;      // dts - min_ts, unsigned
    logic [TS_W:0]     adv_off;      // max - min + step, unsigned
    logic [TS_W-1:0]   adv_base;     // max + step
    logic              adv_base_ovf; // max + step above the signed range
  } ptm_entry_t;

endpackage

### sv/ptm_front.sv
module ptm_front import ptm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [KIND_W-1:0]      func,
  input  logic [STREAM_W-1:0]    stream_id,
  input  logic [TS_W-1:0]        pts_in,
  input  logic                   pts_in_valid,
  input  logic [TS_W-1:0]        dts_in,
  input  logic                   dts_in_valid,
  input  logic [TS_W-1:0]        duration_in,
  input  logic                   q_full,
  output logic                   q_write,
  output ptm_entry_t             q_entry
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    status_t           status;
    logic              act;
    logic [TS_W-1:0]   pts;
    logic              pts_valid;
    logic [TS_W-1:0]   dts;
    logic              dts_valid;
    logic [TS_W-1:0]   dur;
    logic [TS_W-1:0]   min_ts;
    logic [TS_W-1:0]   max_ts;
    logic [TS_W-1:0]   step;
  } ptm_stage_t;

  logic                monotonic_enable;
  logic [STREAM_W-1:0] source_stream;
  logic                st_valid;
  ptm_stage_t          st;
  ptm_stage_t          st_next;
  logic                in_accept;
  logic                pts_lower;
  logic [TS_W:0]       adv_base_sum;
  logic [TS_W-1:0]     span;

  assign full      = st_valid && q_full;
  assign in_accept = push && !full;
  assign q_write   = st_valid && !q_full;
  assign pts_lower = $signed(pts_in) < $signed(dts_in);

  // Classify the request and pick the extreme timestamps.
  always_comb begin
    st_next           = '0;
    st_next.kind      = func;
    st_next.status    = ST_OK;
    st_next.act       = 1'b0;
    st_next.pts       = pts_in;
    st_next.pts_valid = pts_in_valid;
    st_next.dts       = dts_in;
    st_next.dts_valid = dts_in_valid;
    st_next.dur       = duration_in;
    if (func == KIND_DATA) begin
      if (stream_id != source_stream) begin
        st_next.status = ST_WRONG_STREAM;
      end else if (monotonic_enable) begin
        if (!pts_in_valid && !dts_in_valid) begin
          st_next.status = ST_NO_TS;
        end else begin
          st_next.act = 1'b1;
        end
      end
    end
    st_next.min_ts = (pts_in_valid && (!dts_in_valid || pts_lower)) ? pts_in : dts_in;
    st_next.max_ts = (pts_in_valid && (!dts_in_valid || !pts_lower)) ? pts_in : dts_in;
    // Count a duration of zero or below as one.
    st_next.step = (duration_in[TS_W-1] || duration_in == '0) ? TS_W'(1) : duration_in;
  end

  // Precompute every sum that does not need the expected decode time.
  assign adv_base_sum = {st.max_ts[TS_W-1], st.max_ts} + {1'b0, st.step};
  assign span         = st.max_ts - st.min_ts;

  always_comb begin
    q_entry              = '0;
    q_entry.kind         = st.kind;
    q_entry.status       = st.status;
    q_entry.act          = st.act;
    q_entry.pts          = st.pts;
    q_entry.pts_valid    = st.pts_valid;
    q_entry.dts          = st.dts;
    q_entry.dts_valid    = st.dts_valid;
    q_entry.dur          = st.dur;
    q_entry.min_ts       = st.min_ts;
    q_entry.pts_off      = st.pts - st.min_ts;
    q_entry.dts_off      = st.dts - st.min_ts;
    q_entry.adv_off      = {1'b0, span} + {1'b0, st.step};
    q_entry.adv_base     = adv_base_sum[TS_W-1:0];
    q_entry.adv_base_ovf = !adv_base_sum[TS_W] && adv_base_sum[TS_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid         <= 1'b0;
      monotonic_enable <= 1'b0;
      source_stream    <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MONOTONIC_ENABLE: monotonic_enable <= cfg_data[0];
          REG_SOURCE_STREAM:    source_stream    <= cfg_data[STREAM_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        st_valid <= 1'b1;
      end else if (q_write) begin
        st_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      st <= st_next;
    end
  end

endmodule

### sv/ptm_queue.sv
module ptm_queue import ptm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  ptm_entry_t wr_entry,
  output logic       full,
  output logic       rd_valid,
  input  logic       rd_en,
  output ptm_entry_t rd_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ptm_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

### sv/ptm_back.sv
module ptm_back import ptm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  ptm_entry_t          q_entry,
  output logic                q_read,
  input  logic                pop,
  output logic                empty,
  output logic [KIND_W-1:0]   item_kind,
  output logic [STATUS_W-1:0] status,
  output logic [TS_W-1:0]     pts_out,
  output logic                pts_out_valid,
  output logic [TS_W-1:0]     dts_out,
  output logic                dts_out_valid,
  output logic [TS_W-1:0]     duration_out
);

  logic [TS_W-1:0] next_decode_time;
  logic [TS_W-1:0] next_decode_time_next;
  logic            next_time_known;
  logic            out_valid;
  logic            advance;
  logic            shift_on;
  logic [TS_W+1:0] sum_pts;
  logic [TS_W+1:0] sum_dts;
  logic [TS_W+2:0] sum_adv;
  logic            pts_ovf;
  logic            dts_ovf;
  logic            adv_ovf;
  status_t         res_status;
  logic [TS_W-1:0] res_pts;
  logic [TS_W-1:0] res_dts;

  assign empty  = !out_valid;
  assign q_read = q_valid && (!out_valid || pop);

  // Shift applies when the smallest present timestamp falls below the
  // expected time; every shifted value is then expected time plus offset.
  assign shift_on = next_time_known &&
                    ($signed(q_entry.min_ts) < $signed(next_decode_time));
  assign sum_pts  = {{2{next_decode_time[TS_W-1]}}, next_decode_time} +
                    {2'b00, q_entry.pts_off};
  assign sum_dts  = {{2{next_decode_time[TS_W-1]}}, next_decode_time} +
                    {2'b00, q_entry.dts_off};
  assign sum_adv  = {{3{next_decode_time[TS_W-1]}}, next_decode_time} +
                    {2'b00, q_entry.adv_off};
  assign pts_ovf  = !sum_pts[TS_W+1] && (sum_pts[TS_W:TS_W-1] != 2'b00);
  assign dts_ovf  = !sum_dts[TS_W+1] && (sum_dts[TS_W:TS_W-1] != 2'b00);
  assign adv_ovf  = !sum_adv[TS_W+2] && (sum_adv[TS_W+1:TS_W-1] != 3'b000);

  always_comb begin
    res_status            = q_entry.status;
    res_pts               = q_entry.pts;
    res_dts               = q_entry.dts;
    advance               = 1'b0;
    next_decode_time_next = next_decode_time;
    if (q_entry.act) begin
      if (shift_on) begin
        if (q_entry.pts_valid && pts_ovf) begin
          res_status = ST_PTS_OVF;
        end else if (q_entry.dts_valid && dts_ovf) begin
          res_status = ST_DTS_OVF;
        end else if (adv_ovf) begin
          res_status = ST_ADV_OVF;
        end else begin
          advance               = 1'b1;
          next_decode_time_next = sum_adv[TS_W-1:0];
          if (q_entry.pts_valid) begin
            res_pts = sum_pts[TS_W-1:0];
          end
          if (q_entry.dts_valid) begin
            res_dts = sum_dts[TS_W-1:0];
          end
        end
      end else if (q_entry.adv_base_ovf) begin
        res_status = ST_ADV_OVF;
      end else begin
        advance               = 1'b1;
        next_decode_time_next = q_entry.adv_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      next_time_known  <= 1'b0;
      next_decode_time <= '0;
    end else begin
      if (q_read) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_read && advance) begin
        next_decode_time <= next_decode_time_next;
        next_time_known  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_read) begin
      item_kind     <= q_entry.kind;
      status        <= res_status;
      pts_out       <= res_pts;
      pts_out_valid <= q_entry.pts_valid;
      dts_out       <= res_dts;
      dts_out_valid <= q_entry.dts_valid;
      duration_out  <= q_entry.dur;
    end
  end

endmodule

### sv/packet_timestamp_monotonizer.sv
// Channel   Handshake          Payload
// --------  -----------------  ---------------------------------------------------
// request   push / full        func, stream_id, pts_in(_valid), dts_in(_valid),
//                              duration_in
// result    empty / pop        item_kind, status, pts_out(_valid), dts_out(_valid),
//                              duration_out
// config    cfg_write          cfg_index, cfg_data (no wait, no read-back)
//
// One request per cycle sustained while results are popped; each request passes
// the front stage register and the queue before the back registers its result.
// The back stage sets the rate; it updates the expected decode time per request.
// Reset (rst, synchronous) empties all stages and clears the expected time and
// both registers. A result held by a low pop stalls the back stage only; the
// front keeps taking requests until the queue and its own stage are occupied.
module packet_timestamp_monotonizer import ptm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  logic                   push,
  output logic                   full,
  input  logic [KIND_W-1:0]      func,
  input  logic [STREAM_W-1:0]    stream_id,
  input  logic signed [TS_W-1:0] pts_in,
  input  logic                   pts_in_valid,
  input  logic signed [TS_W-1:0] dts_in,
  input  logic                   dts_in_valid,
  input  logic signed [TS_W-1:0] duration_in,
  // result channel
  output logic                   empty,
  input  logic                   pop,
  output logic [KIND_W-1:0]      item_kind,
  output logic [STATUS_W-1:0]    status,
  output logic signed [TS_W-1:0] pts_out,
  output logic                   pts_out_valid,
  output logic signed [TS_W-1:0] dts_out,
  output logic                   dts_out_valid,
  output logic signed [TS_W-1:0] duration_out
);

  // Front to queue.
  logic       q_write;
  logic       q_full;
  ptm_entry_t q_wr_entry;
  // Queue to back.
  logic       q_valid;
  logic       q_read;
  ptm_entry_t q_rd_entry;

  // Classify each request, apply the stream and timestamp checks, and
  // precompute all sums that do not depend on the expected decode time.
  ptm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .func         (func),
    .stream_id    (stream_id),
    .pts_in       (pts_in),
    .pts_in_valid (pts_in_valid),
    .dts_in       (dts_in),
    .dts_in_valid (dts_in_valid),
    .duration_in  (duration_in),
    .q_full       (q_full),
    .q_write      (q_write),
    .q_entry      (q_wr_entry)
  );

  // Decouple the front from a stalled result side.
  ptm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_write),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_read),
    .rd_entry (q_rd_entry)
  );

  // Hold the expected decode time, shift late timestamps, check overflow,
  // and drive the registered result.
  ptm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (q_rd_entry),
    .q_read        (q_read),
    .pop           (pop),
    .empty         (empty),
    .item_kind     (item_kind),
    .status        (status),
    .pts_out       (pts_out),
    .pts_out_valid (pts_out_valid),
    .dts_out       (dts_out),
    .dts_out_valid (dts_out_valid),
    .duration_out  (duration_out)
  );

endmodule

### sv/ptm_checker.sv
`include "packet_timestamp_monotonizer_assert.svh"

module ptm_checker import ptm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [KIND_W-1:0]   item_kind,
  input logic [STATUS_W-1:0] status,
  input logic [TS_W-1:0]     pts_out,
  input logic                pts_out_valid,
  input logic [TS_W-1:0]     dts_out,
  input logic                dts_out_valid,
  input logic [TS_W-1:0]     duration_out
);

  `PTM_ASSERT_ALL(a_reset_idle, clk, rst |=> (empty && !full), "not idle after reset")

  `PTM_ASSERT(a_result_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(item_kind) && $stable(status) && $stable(pts_out) && $stable(dts_out) && $stable(duration_out)), "stalled result changed")

  `PTM_ASSERT(a_marker_ok, clk, rst, (!empty && item_kind != KIND_DATA) |-> (status == ST_OK), "marker with nonzero status")

  `PTM_ASSERT(a_no_ts, clk, rst, (!empty && status == ST_NO_TS) |-> (!pts_out_valid && !dts_out_valid), "no-timestamp status with a timestamp present")

  `PTM_ASSERT(a_ovf_present, clk, rst, (!empty && (status == ST_PTS_OVF || status == ST_DTS_OVF)) |-> (status == ST_PTS_OVF ? pts_out_valid : dts_out_valid), "overflow status on an absent timestamp")

endmodule

bind packet_timestamp_monotonizer ptm_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .item_kind     (item_kind),
  .status        (status),
  .pts_out       (pts_out),
  .pts_out_valid (pts_out_valid),
  .dts_out       (dts_out),
  .dts_out_valid (dts_out_valid),
  .duration_out  (duration_out)
);

### tb/sv/ptm_stamp_checker.sv
`timescale 1ns / 1ps

module ptm_stamp_checker import ptm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  input  logic                   full,
  input  logic [KIND_W-1:0]      func,
  input  logic [STREAM_W-1:0]    stream_id,
  input  logic [TS_W-1:0]        pts_in,
  input  logic                   pts_in_valid,
  input  logic [TS_W-1:0]        dts_in,
  input  logic                   dts_in_valid,
  input  logic [TS_W-1:0]        duration_in,
  input  logic                   empty,
  input  logic                   pop,
  input  logic [KIND_W-1:0]      item_kind,
  input  logic [STATUS_W-1:0]    status,
  input  logic [TS_W-1:0]        pts_out,
  input  logic                   pts_out_valid,
  input  logic [TS_W-1:0]        dts_out,
  input  logic                   dts_out_valid,
  input  logic [TS_W-1:0]        duration_out,
  output int                     mismatches,
  output int                     in_flight,
  output int                     checked
);

  localparam logic [TS_W-1:0] TS_MAX = {1'b0, {(TS_W-1){1'b1}}};

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic [TS_W-1:0]     pts;
    logic                pts_valid;
    logic [TS_W-1:0]     dts;
    logic                dts_valid;
    logic [TS_W-1:0]     dur;
  } stamp_t;

  logic                mono_mode;
  logic [STREAM_W-1:0] accept_stream;
  logic [TS_W-1:0]     expected_decode_time;
  logic                decode_time_known;
  stamp_t              expected_stamps [$];

  // Distance up to the signed maximum; exact for every 64-bit pattern.
  function automatic logic [TS_W-1:0] headroom(logic [TS_W-1:0] v);
    return TS_MAX - v;
  endfunction

  function automatic logic below(logic [TS_W-1:0] a, logic [TS_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Work out the result of one request and advance the expected decode time.
  function automatic stamp_t monotonize(stamp_t req, logic [STREAM_W-1:0] sid);
    stamp_t          res;
    logic [TS_W-1:0] shift;
    logic [TS_W-1:0] gap;
    logic [TS_W-1:0] latest;
    logic [TS_W-1:0] step;
    res = req;
    res.status = ST_OK;
    if (req.kind == KIND_DATA) begin
      if (sid != accept_stream) begin
        res.status = ST_WRONG_STREAM;
      end else if (mono_mode) begin
        if (!req.pts_valid && !req.dts_valid) begin
          res.status = ST_NO_TS;
        end else begin
          shift = '0;
          if (decode_time_known) begin
            gap = expected_decode_time - req.dts;
            if (req.dts_valid && below(req.dts, expected_decode_time) && gap > shift)
              shift = gap;
            gap = expected_decode_time - req.pts;
            if (req.pts_valid && below(req.pts, expected_decode_time) && gap > shift)
              shift = gap;
          end
          if (shift != '0) begin
            if (req.pts_valid) begin
              if (shift > headroom(req.pts)) res.status = ST_PTS_OVF;
              else res.pts = req.pts + shift;
            end
            if (res.status == ST_OK && req.dts_valid) begin
              if (shift > headroom(req.dts)) res.status = ST_DTS_OVF;
              else res.dts = req.dts + shift;
            end
          end
          if (res.status == ST_OK) begin
            latest = req.dts_valid ? res.dts : res.pts;
            if (req.pts_valid && below(latest, res.pts)) latest = res.pts;
            step = below(req.dur, 64'd1) ? 64'd1 : req.dur;
            if (step > headroom(latest)) begin
              res.status = ST_ADV_OVF;
            end else begin
              expected_decode_time = latest + step;
              decode_time_known = 1'b1;
            end
          end
          if (res.status != ST_OK) begin
            res.pts = req.pts;
            res.dts = req.dts;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    stamp_t got;
    stamp_t want;
    if (rst) begin
      mono_mode = 1'b0;
      accept_stream = '0;
      expected_decode_time = '0;
      decode_time_known = 1'b0;
      expected_stamps.delete();
      in_flight <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MONOTONIC_ENABLE) mono_mode = cfg_data[0];
        else if (cfg_index == REG_SOURCE_STREAM) accept_stream = cfg_data[STREAM_W-1:0];
      end
      if (pop && !empty) begin
        got = {item_kind, status, pts_out, pts_out_valid, dts_out, dts_out_valid,
               duration_out};
        checked++;
        if (expected_stamps.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result %0d arrived with nothing expected", $time, checked);
          mismatches++;
        end else begin
          want = expected_stamps.pop_front();
          if (got.kind !== want.kind || got.status !== want.status ||
              got.pts !== want.pts || got.pts_valid !== want.pts_valid ||
              got.dts !== want.dts || got.dts_valid !== want.dts_valid ||
              got.dur !== want.dur) begin
            if (mismatches < 10) begin
              $display("%0t: result %0d mismatch", $time, checked);
              $display("  expected kind %0d status %0d pts %h/%b dts %h/%b dur %h",
                       want.kind, want.status, want.pts, want.pts_valid,
                       want.dts, want.dts_valid, want.dur);
              $display("  actual   kind %0d status %0d pts %h/%b dts %h/%b dur %h",
                       got.kind, got.status, got.pts, got.pts_valid,
                       got.dts, got.dts_valid, got.dur);
            end
            mismatches++;
          end
        end
      end
      if (push && !full)
        expected_stamps.push_back(monotonize({func, ST_OK, pts_in, pts_in_valid, dts_in,
                                              dts_in_valid, duration_in}, stream_id));
      in_flight <= expected_stamps.size();
    end
  end

endmodule

### tb/sv/tb_packet_timestamp_monotonizer.sv
`timescale 1ns / 1ps

module tb_packet_timestamp_monotonizer;
  import ptm_pkg::*;

  // The spare kind code passes through like a marker.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic [TS_W-1:0] TS_MAX = {1'b0, {(TS_W-1){1'b1}}};
  localparam logic [TS_W-1:0] TS_MIN = {1'b1, {(TS_W-1){1'b0}}};

  localparam int PHASES       = 7;
  localparam int PER_PHASE    = 250;    // 7 x 250 random requests
  localparam int LONG_HOLD    = 150;    // output held off this many cycles once
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [STREAM_W-1:0] stream;
    logic [TS_W-1:0]     pts;
    logic                pts_valid;
    logic [TS_W-1:0]     dts;
    logic                dts_valid;
    logic [TS_W-1:0]     dur;
  } request_t;

  localparam int REQ_W = $bits(request_t);

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [KIND_W-1:0]      func = '0;
  logic [STREAM_W-1:0]    stream_id = '0;
  logic signed [TS_W-1:0] pts_in = '0;
  logic                   pts_in_valid = 1'b0;
  logic signed [TS_W-1:0] dts_in = '0;
  logic                   dts_in_valid = 1'b0;
  logic signed [TS_W-1:0] duration_in = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [KIND_W-1:0]      item_kind;
  logic [STATUS_W-1:0]    status;
  logic signed [TS_W-1:0] pts_out;
  logic                   pts_out_valid;
  logic signed [TS_W-1:0] dts_out;
  logic                   dts_out_valid;
  logic signed [TS_W-1:0] duration_out;

  int mismatches;
  int in_flight;
  int checked;

  // Stimulus state shared between the sender and the receiver.
  logic [STREAM_W-1:0] cur_stream = '0;
  logic [TS_W-1:0]     ts_base = '0;
  bit                  wild = 1'b0;       // allow extreme and fully random timestamps
  bit                  calm = 1'b0;       // no idling on either side
  bit                  long_hold_req = 1'b0;
  int                  pop_wait;
  int                  long_holds;
  int                  sent;
  int                  cycles;

  packet_timestamp_monotonizer dut (.*);

  ptm_stamp_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Give up at a generous limit; a correct run ends well before it.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, in_flight);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: take results, with random stall bursts and one long hold-off
  // that the sender asks for. Count the hold in cycles here.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_wait > 0) begin
      pop <= 1'b0;
      pop_wait--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      long_holds++;
      pop <= 1'b0;
      pop_wait = LONG_HOLD - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      pop_wait = $urandom_range(1, 13) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // Put one request on the input fields; push is handled by the callers.
  task automatic drive(request_t r);
    func <= r.kind;
    stream_id <= r.stream;
    pts_in <= r.pts;
    pts_in_valid <= r.pts_valid;
    dts_in <= r.dts;
    dts_in_valid <= r.dts_valid;
    duration_in <= r.dur;
  endtask

  // Offer a request and hold it until the block takes it. Leave push high so
  // a following request goes out back to back.
  task automatic send(request_t r);
    drive(r);
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  // Idle the input with junk on the fields, which must be ignored.
  task automatic pause_sender(int n);
    request_t junk;
    push <= 1'b0;
    repeat (n) begin
      junk = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      drive(junk);
      @(posedge clk);
    end
  endtask

  // Stop sending and wait for every expected result, then let the pipe settle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers; the spare bits of the enable write carry junk.
  task automatic configure(logic mono, logic [STREAM_W-1:0] sid);
    logic [CFG_DATA_W-2:0] junk;
    junk = (CFG_DATA_W-1)'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= REG_MONOTONIC_ENABLE;
    cfg_data <= {junk, mono};
    @(posedge clk);
    cfg_index <= REG_SOURCE_STREAM;
    cfg_data <= sid;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_stream = sid;
  endtask

  function automatic request_t make_packet(logic [KIND_W-1:0] kind,
                                           logic [STREAM_W-1:0] sid,
                                           logic [TS_W-1:0] pts, logic pv,
                                           logic [TS_W-1:0] dts, logic dv,
                                           logic [TS_W-1:0] dur);
    request_t r;
    r.kind = kind;
    r.stream = sid;
    r.pts = pts;
    r.pts_valid = pv;
    r.dts = dts;
    r.dts_valid = dv;
    r.dur = dur;
    return r;
  endfunction

  // Build a random request. Most are packets of the configured stream whose
  // timestamps follow a running time base, now and then slightly behind it so
  // the block must shift them. Extremes only come in wild phases, since the
  // expected time never moves down again once it is near the top.
  function automatic request_t random_packet();
    request_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    r.kind = pick < 84 ? KIND_DATA : pick < 91 ? KIND_FLUSH : pick < 97 ? KIND_END : KIND_SPARE;
    r.stream = cur_stream;
    if ($urandom_range(0, 9) == 0) r.stream = STREAM_W'($urandom);

    pick = $urandom_range(0, 19);
    r.pts_valid = !(pick == 0 || pick == 3 || pick == 4);
    r.dts_valid = !(pick == 0 || pick == 1 || pick == 2);

    pick = wild ? $urandom_range(0, 9) : 0;
    if (pick < 4) begin
      ts_base = ts_base + TS_W'($urandom_range(0, 150));
      r.dts = ts_base - TS_W'($urandom_range(0, 30));
      r.pts = r.dts + TS_W'($urandom_range(0, 60)) - TS_W'(10);
    end else if (pick < 6) begin
      r.dts = {$urandom, $urandom};
      r.pts = {$urandom, $urandom};
    end else if (pick < 8) begin
      r.dts = TS_MAX - TS_W'($urandom_range(0, 50));
      r.pts = TS_MAX - TS_W'($urandom_range(0, 50));
    end else if (pick < 9) begin
      r.dts = TS_MIN + TS_W'($urandom_range(0, 50));
      r.pts = TS_MIN + TS_W'($urandom_range(0, 50));
    end else begin
      // jump the time base: either anywhere or close below the top
      if ($urandom_range(0, 1) == 0) ts_base = {$urandom, $urandom} >> $urandom_range(1, 40);
      else ts_base = TS_MAX - TS_W'($urandom_range(0, 3000));
      r.dts = ts_base;
      r.pts = ts_base + TS_W'($urandom_range(0, 20));
    end

    pick = $urandom_range(0, 9);
    if (pick < 7) r.dur = TS_W'($urandom_range(1, 30));
    else if (pick < 8) r.dur = '0;
    else if (pick < 9 || !wild) r.dur = {1'b1, (TS_W-33)'($urandom), $urandom};  // negative counts as one
    else if ($urandom_range(0, 1) == 0) r.dur = {$urandom, $urandom};
    else r.dur = TS_MAX - TS_W'($urandom_range(0, 50));
    return r;
  endfunction

  initial begin : stimulus
    logic                mode_mono [PHASES];
    logic [STREAM_W-1:0] mode_stream [PHASES];
    bit                  mode_wild [PHASES];
    int                  rush;

    // Register settings per phase; streams of zero in phases 4 and 6 are
    // replaced by random picks below.
    mode_mono   = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    mode_stream = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h5A, 8'h00};
    mode_wild   = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    rush = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    configure(1'b1, 8'h5A);

    // Directed: markers, the spare kind, wrong stream, missing timestamps,
    // then a packet chain that shifts, overflows and advances the time.
    // Overflow cases keep the expected time low so later phases stay useful.
    send(make_packet(KIND_FLUSH, 8'h00, TS_MAX, 1'b1, TS_MIN, 1'b0, '0));
    send(make_packet(KIND_END, 8'hFF, '0, 1'b0, '1, 1'b1, TS_MIN));
    send(make_packet(KIND_SPARE, 8'h5A, -5, 1'b1, -9, 1'b1, 3));
    send(make_packet(KIND_DATA, 8'h5B, 5, 1'b1, 5, 1'b1, 1));
    send(make_packet(KIND_DATA, 8'h5A, 77, 1'b0, 88, 1'b0, 3));
    // first packet: nothing to compare against yet
    send(make_packet(KIND_DATA, 8'h5A, -1990, 1'b1, -2000, 1'b1, 10));
    // both behind: shift by the shortfall
    send(make_packet(KIND_DATA, 8'h5A, -2490, 1'b1, -2500, 1'b1, 10));
    // presentation time alone, behind; zero duration counts as one
    send(make_packet(KIND_DATA, 8'h5A, -3000, 1'b1, 1234, 1'b0, 0));
    // decode time alone, exactly on time; negative duration
    send(make_packet(KIND_DATA, 8'h5A, 4321, 1'b0, -1959, 1'b1, -7));
    // presentation time below decode time, only it falls short
    send(make_packet(KIND_DATA, 8'h5A, -2000, 1'b1, -1000, 1'b1, 5));
    // presentation time overflows on the shift
    send(make_packet(KIND_DATA, 8'h5A, TS_MAX - 100, 1'b1, -5953, 1'b1, 5));
    // shortfall close to the signed maximum; decode time overflows
    send(make_packet(KIND_DATA, 8'h5A, TS_MIN, 1'b1, TS_MAX - 3, 1'b1, 5));
    // advance overflows near the top
    send(make_packet(KIND_DATA, 8'h5A, TS_MAX - 2, 1'b1, TS_MAX - 2, 1'b1, 10));
    // advance overflows on a huge duration
    send(make_packet(KIND_DATA, 8'h5A, 1, 1'b1, 1, 1'b1, TS_MAX));
    // decode time behind, presentation time ahead
    send(make_packet(KIND_DATA, 8'h5A, 5000, 1'b1, -1000, 1'b1, 0));
    // most negative duration counts as one
    send(make_packet(KIND_DATA, 8'h5A, 6000, 1'b1, 6000, 1'b1, TS_MIN));
    send(make_packet(KIND_DATA, 8'h5A, 6001, 1'b1, 6001, 1'b1, 1));
    ts_base = 6000;

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 4 || p == 6) mode_stream[p] = STREAM_W'($urandom);
      configure(mode_mono[p], mode_stream[p]);
      wild = mode_wild[p];
      calm = (p == PHASES - 1);
      for (int i = 0; i < PER_PHASE; i++) begin
        // Hold the output off and keep offering back to back so the block fills.
        if (p == 1 && i == 40) begin
          long_hold_req = 1'b1;
          rush = 30;
        end
        // Hold the input until everything is out, mid phase.
        if (p == 2 && i == PER_PHASE / 2) drain();
        send(random_packet());
        if (rush > 0) rush--;
        else if (!calm && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 13));
      end
    end
    drain();

    $display("Checked %0d results of %0d requests under %0d register settings, %0d long stall(s).",
             checked, sent, PHASES + 1, long_holds);
    if (mismatches == 0 && in_flight == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
